@@ rtl/sseq_pkg.sv @@
// ----------------------------------------------------------------------------
// sseq_pkg
// Shared constants, widths and codes for the step sequencer with glide.
// ----------------------------------------------------------------------------
package sseq_pkg;

    localparam int NUM_STEPS   = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int STEP_W      = 4;
    localparam int LOOP_W      = 5;
    localparam int KEEP_W      = 15;
    localparam int CFG_IDX_W   = 2;

    // stream payload layout
    localparam int IN_DATA_W   = 3 * SAMPLE_BITS + STEP_W + SAMPLE_BITS;
    localparam int IN_TDATA_W  = ((IN_DATA_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = SAMPLE_BITS + STEP_W;
    localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

    localparam int RST_LO   = 0;
    localparam int FWD_LO   = SAMPLE_BITS;
    localparam int BWD_LO   = 2 * SAMPLE_BITS;
    localparam int SLOT_LO  = 3 * SAMPLE_BITS;
    localparam int SVAL_LO  = 3 * SAMPLE_BITS + STEP_W;

    // register reset values
    localparam logic [LOOP_W-1:0]             LOOP_LENGTH_RST = LOOP_W'(16);
    localparam logic [KEEP_W-1:0]             GLIDE_KEEP_RST  = '0;
    localparam logic signed [SAMPLE_BITS-1:0] HIGH_THR_RST    = SAMPLE_BITS'(1638);
    localparam logic signed [SAMPLE_BITS-1:0] LOW_THR_RST     = SAMPLE_BITS'(328);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOOP_LENGTH = 2'd0,
        CFG_GLIDE_KEEP  = 2'd1,
        CFG_HIGH_THR    = 2'd2,
        CFG_LOW_THR     = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_WRITE = 1'b1
    } t_cmd;

endpackage

@@ rtl/sseq_skid.sv @@
// ----------------------------------------------------------------------------
// sseq_skid
// Two-entry output register: result register plus skid stage, so the
// upstream ready comes from a flop and never from the downstream ready.
// ----------------------------------------------------------------------------
module sseq_skid #(
    parameter int DATA_W = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_ready,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data,
    input  logic              i_ready
);

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic              r_skid_valid;
    logic [DATA_W-1:0] r_skid_data;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_valid;
                r_out_data  <= i_data;
            end
        end else if (i_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
            r_skid_data  <= i_data;
        end
    end

endmodule

@@ rtl/step_sequencer_with_glide.sv @@
// ----------------------------------------------------------------------------
// step_sequencer_with_glide
// Sixteen-step sequencer with Schmitt-triggered forward/back stepping,
// level reset and a one-pole glide filter on the current step value.
// ----------------------------------------------------------------------------
// Takes one item per clock. A sample tick updates position, trigger arming
// and filter level in the cycle it is accepted (store read, one 17x17
// multiply, add) and its result enters a two-deep output register; a step
// write updates the store and gives no result. Input ready drops only while
// both output entries are full. The step store is cleared by reset at once,
// with no sweep.
module step_sequencer_with_glide
    import sseq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave side
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // [15:0] reset_level, [31:16] forward_level, [47:32] backward_level,
    // [51:48] slot, [67:52] slot_value, [71:68] zero
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // [0] cmd
    input  logic                   i_s_tuser,
    // master side
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // [15:0] smoothed_out, [19:16] current_step, [23:20] zero
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    // configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [SAMPLE_BITS-1:0] i_cfg_data
);

    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int GAIN_W = KEEP_W + 2;
    localparam int PROD_W = DIFF_W + GAIN_W;

    // configuration
    logic [LOOP_W-1:0]             r_loop_length;
    logic [KEEP_W-1:0]             r_glide_keep;
    logic signed [SAMPLE_BITS-1:0] r_high_thr;
    logic signed [SAMPLE_BITS-1:0] r_low_thr;

    // state
    logic signed [SAMPLE_BITS-1:0] r_step_store [NUM_STEPS];
    logic [STEP_W-1:0]             r_pos;
    logic signed [SAMPLE_BITS-1:0] r_level;
    logic                          r_fwd_off;
    logic                          r_bwd_off;

    logic [STEP_W-1:0]             n_pos;
    logic signed [SAMPLE_BITS-1:0] n_level;
    logic                          n_fwd_off;
    logic                          n_bwd_off;

    logic                          w_accept;
    logic                          w_tick;
    logic                          w_write;
    logic                          w_skid_ready;
    logic signed [SAMPLE_BITS-1:0] w_rst_lvl;
    logic signed [SAMPLE_BITS-1:0] w_fwd_lvl;
    logic signed [SAMPLE_BITS-1:0] w_bwd_lvl;
    logic [STEP_W-1:0]             w_slot;
    logic signed [SAMPLE_BITS-1:0] w_slot_val;
    logic [LOOP_W-1:0]             w_loop;
    logic [LOOP_W-1:0]             w_fwd_inc;
    logic [STEP_W-1:0]             w_pos_f;
    logic signed [SAMPLE_BITS-1:0] w_target;
    logic signed [DIFF_W-1:0]      w_diff;
    logic signed [GAIN_W-1:0]      w_gain;
    logic signed [PROD_W-1:0]      w_prod;
    logic signed [PROD_W-1:0]      w_delta;
    logic [OUT_TDATA_W-1:0]        w_res_data;

    assign o_s_tready = w_skid_ready;
    assign o_cfg_ready = 1'b1;
    assign w_accept   = i_s_tvalid && w_skid_ready;
    assign w_tick     = w_accept && (t_cmd'(i_s_tuser) == CMD_TICK);
    assign w_write    = w_accept && (t_cmd'(i_s_tuser) == CMD_WRITE);

    assign w_rst_lvl  = i_s_tdata[RST_LO +: SAMPLE_BITS];
    assign w_fwd_lvl  = i_s_tdata[FWD_LO +: SAMPLE_BITS];
    assign w_bwd_lvl  = i_s_tdata[BWD_LO +: SAMPLE_BITS];
    assign w_slot     = i_s_tdata[SLOT_LO +: STEP_W];
    assign w_slot_val = i_s_tdata[SVAL_LO +: SAMPLE_BITS];

    // effective loop length, 1..NUM_STEPS
    always_comb begin
        if (r_loop_length == '0) begin
            w_loop = LOOP_W'(1);
        end else if (r_loop_length > LOOP_W'(NUM_STEPS)) begin
            w_loop = LOOP_W'(NUM_STEPS);
        end else begin
            w_loop = r_loop_length;
        end
    end

    // position and trigger arming
    always_comb begin
        n_fwd_off = r_fwd_off;
        n_bwd_off = r_bwd_off;
        w_fwd_inc = {1'b0, r_pos} + LOOP_W'(1);
        w_pos_f   = r_pos;
        n_pos     = r_pos;
        if (w_rst_lvl > 0) begin
            n_pos = '0;
        end else begin
            if (w_fwd_lvl > r_high_thr && !r_fwd_off) begin
                n_fwd_off = 1'b1;
                w_pos_f   = (w_fwd_inc >= w_loop) ? '0 : w_fwd_inc[STEP_W-1:0];
            end else if (w_fwd_lvl <= r_low_thr) begin
                n_fwd_off = 1'b0;
            end
            n_pos = w_pos_f;
            if (w_bwd_lvl > r_high_thr && !r_bwd_off) begin
                n_bwd_off = 1'b1;
                if (w_pos_f == '0) begin
                    n_pos = STEP_W'(w_loop - LOOP_W'(1));
                end else begin
                    n_pos = w_pos_f - STEP_W'(1);
                end
            end else if (w_bwd_lvl <= r_low_thr) begin
                n_bwd_off = 1'b0;
            end
        end
    end

    // glide filter, floor shift
    assign w_target = r_step_store[n_pos];
    assign w_diff   = DIFF_W'(w_target) - DIFF_W'(r_level);
    assign w_gain   = GAIN_W'(32768) - GAIN_W'({1'b0, r_glide_keep});
    assign w_prod   = PROD_W'(w_diff) * PROD_W'(w_gain);
    assign w_delta  = w_prod >>> 15;
    assign n_level  = r_level + w_delta[SAMPLE_BITS-1:0];

    assign w_res_data = OUT_TDATA_W'({n_pos, n_level});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop_length <= LOOP_LENGTH_RST;
            r_glide_keep  <= GLIDE_KEEP_RST;
            r_high_thr    <= HIGH_THR_RST;
            r_low_thr     <= LOW_THR_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LOOP_LENGTH: r_loop_length <= i_cfg_data[LOOP_W-1:0];
                CFG_GLIDE_KEEP:  r_glide_keep  <= i_cfg_data[KEEP_W-1:0];
                CFG_HIGH_THR:    r_high_thr    <= i_cfg_data;
                CFG_LOW_THR:     r_low_thr     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_level   <= '0;
            r_fwd_off <= 1'b0;
            r_bwd_off <= 1'b0;
            for (int i = 0; i < NUM_STEPS; i++) begin
                r_step_store[i] <= '0;
            end
        end else if (w_tick) begin
            r_pos     <= n_pos;
            r_level   <= n_level;
            r_fwd_off <= n_fwd_off;
            r_bwd_off <= n_bwd_off;
        end else if (w_write) begin
            if ({1'b0, w_slot} < (STEP_W + 1)'(NUM_STEPS)) begin
                r_step_store[w_slot] <= w_slot_val;
            end
        end
    end

    sseq_skid #(
        .DATA_W (OUT_TDATA_W)
    ) u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_tick),
        .i_data  (w_res_data),
        .o_ready (w_skid_ready),
        .o_valid (o_m_tvalid),
        .o_data  (o_m_tdata),
        .i_ready (i_m_tready)
    );

endmodule

@@ rtl/sseq_checker.sv @@
// ----------------------------------------------------------------------------
// sseq_checker
// Port-level checks for the step sequencer with glide, bound to the top.
// ----------------------------------------------------------------------------
module sseq_checker
    import sseq_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic [IN_TDATA_W-1:0]  i_s_tdata,
    input logic                   i_s_tuser,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata,
    input logic                   i_cfg_valid,
    input logic                   o_cfg_ready,
    input logic [CFG_IDX_W-1:0]   i_cfg_index,
    input logic [SAMPLE_BITS-1:0] i_cfg_data
);

    logic w_tick_acc;
    logic w_write_acc;

    assign w_tick_acc  = i_s_tvalid && o_s_tready && (t_cmd'(i_s_tuser) == CMD_TICK);
    assign w_write_acc = i_s_tvalid && o_s_tready && (t_cmd'(i_s_tuser) == CMD_WRITE);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // a new result needs a tick transaction in the cycle before
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !$past(o_m_tvalid) |-> $past(w_tick_acc))
        else $error("result without tick");

    // write transactions give no result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_write_acc && !o_m_tvalid |=> !o_m_tvalid)
        else $error("result after step write");

    // back-pressure only with a result pending
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("not ready with empty output");

endmodule

bind step_sequencer_with_glide sseq_checker u_sseq_checker (.*);
